@@ hdl/lcc_pkg.sv @@
// Package for the keypad code lock controller: codes, widths and the structs
// that travel between the front end, the command queue and the execution stage.
// Depends on nothing; every other file imports it.
`default_nettype none

package lcc_pkg;

   // Number of keys in one code entry (range 4 to 16).
   localparam int CODE_LENGTH = 10;
   localparam int CODE_W      = 4 * CODE_LENGTH;
   localparam int IDX_W       = $clog2(CODE_LENGTH);

   localparam int MASTER_W = 40;
   localparam int THR_W    = 8;
   localparam int UNIT_W   = 4;
   localparam int FAIL_W   = 8;
   localparam int LOCK_W   = 12;
   localparam int KEYS_W   = 4;
   localparam int KEY_W    = 4;

   localparam logic [MASTER_W-1:0] MASTER_RESET = 40'h32882DCBA0;
   localparam logic [63:0]         MASTER_WIDE  = 64'(MASTER_RESET);
   localparam logic [CODE_W-1:0]   STORED_RESET = MASTER_WIDE[CODE_W-1:0];
   localparam logic [THR_W-1:0]    THR_RESET    = 8'd5;
   localparam logic [UNIT_W-1:0]   UNIT_RESET   = 4'd5;
   localparam logic [FAIL_W-1:0]   FAIL_MAX     = 8'd255;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT      = 2'd2;

   // Special keys.
   localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
   localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

   // Input word kinds carried in tuser.
   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Lock modes.
   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_ENTER   = 3'd1;
   localparam logic [2:0] M_OLD     = 3'd2;
   localparam logic [2:0] M_NEW     = 3'd3;
   localparam logic [2:0] M_CONFIRM = 3'd4;
   localparam logic [2:0] M_LOCKED  = 3'd5;

   // Result events.
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_TAKEN     = 3'd1;
   localparam logic [2:0] EV_UNLOCK    = 3'd2;
   localparam logic [2:0] EV_WRONG     = 3'd3;
   localparam logic [2:0] EV_CHANGED   = 3'd4;
   localparam logic [2:0] EV_MISMATCH  = 3'd5;
   localparam logic [2:0] EV_IGNORED   = 3'd6;
   localparam logic [2:0] EV_LOCK_OVER = 3'd7;

   // Command queue geometry.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // A classified input word.
   typedef struct packed {
      logic             is_tick;
      logic             is_star;
      logic             is_marker;  // star or hash
      logic [KEY_W-1:0] key;
   } cmd_type;

   // Configuration registers.
   typedef struct packed {
      logic [MASTER_W-1:0] master;
      logic [THR_W-1:0]    threshold;
      logic [UNIT_W-1:0]   unit;
   } cfg_type;

   // Live state of the execution stage.
   typedef struct packed {
      logic [2:0]        mode;
      logic [KEYS_W-1:0] keys;
      logic [LOCK_W-1:0] lockout;
   } stat_type;

endpackage

`default_nettype wire

@@ hdl/lcc_front.sv @@
// Front end of the keypad code lock controller: accepts input words and
// classifies them into commands for the queue. Depends on lcc_pkg.
`default_nettype none

module lcc_front (
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [lcc_pkg::REQ_DATA_W-1:0] req_tdata,  // [3:0] key_code
   input  wire logic                          req_tuser,  // [0] req_type
   input  wire logic                          q_full,
   output logic                               q_push,
   output lcc_pkg::cmd_type                   q_cmd
);
   import lcc_pkg::*;

   logic [KEY_W-1:0] key;

   assign key        = req_tdata[KEY_W-1:0];
   assign req_tready = ~q_full;
   assign q_push     = req_tvalid & ~q_full;

   always_comb begin
      q_cmd.is_tick   = (req_tuser == REQ_TICK);
      q_cmd.is_star   = (key == KEY_STAR);
      q_cmd.is_marker = (key == KEY_STAR) || (key == KEY_HASH);
      q_cmd.key       = key;
   end

endmodule

`default_nettype wire

@@ hdl/lcc_queue.sv @@
// Short command queue between the front end and the execution stage.
// Depends on lcc_pkg for the command type and depth.
`default_nettype none

module lcc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lcc_pkg::cmd_type din,
   output logic                  full,
   input  wire logic             pop,
   output lcc_pkg::cmd_type      dout,
   output logic                  valid
);
   import lcc_pkg::*;

   cmd_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign valid = (count_ff != '0);
   assign dout  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/lcc_back.sv @@
// Execution stage of the keypad code lock controller: runs the lock state
// machine on queued commands and holds the result word. Depends on lcc_pkg.
`default_nettype none

module lcc_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_valid,
   input  wire lcc_pkg::cmd_type               q_cmd,
   output logic                                q_pop,
   input  wire lcc_pkg::cfg_type               cfg,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [lcc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output lcc_pkg::stat_type                   stat
);
   import lcc_pkg::*;

   logic [2:0]        mode_ff, mode_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [FAIL_W-1:0] fail_ff, fail_in;
   logic [LOCK_W-1:0] lock_ff, lock_in;
   logic [CODE_W-1:0] stored_ff, stored_in;
   logic [CODE_W-1:0] entry_ff, entry_in;
   logic [CODE_W-1:0] newc_ff, newc_in;
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [2:0]        ev;
   logic [CODE_W-1:0] entry_full;
   logic [CODE_W-1:0] master_cmp;
   logic [63:0]       master_wide;
   logic [FAIL_W-1:0] fail_inc;
   logic [LOCK_W-1:0] lock_time;
   logic [LOCK_W-1:0] lock_dec;

   assign q_pop = q_valid & (~rsp_valid_ff | rsp_tready);

   assign master_wide = 64'(cfg.master);
   assign master_cmp  = master_wide[CODE_W-1:0];
   assign fail_inc    = (fail_ff == FAIL_MAX) ? fail_ff : fail_ff + 1'b1;
   assign lock_time   = LOCK_W'(fail_inc) * LOCK_W'(cfg.unit);
   assign lock_dec    = (lock_ff != '0) ? lock_ff - 1'b1 : lock_ff;

   always_comb begin
      entry_full = entry_ff;
      entry_full[4*idx_ff +: 4] = q_cmd.key;
   end

   always_comb begin
      mode_in   = mode_ff;
      idx_in    = idx_ff;
      fail_in   = fail_ff;
      lock_in   = lock_ff;
      stored_in = stored_ff;
      entry_in  = entry_ff;
      newc_in   = newc_ff;
      ev        = EV_NONE;
      if (q_cmd.is_tick) begin
         if (mode_ff == M_LOCKED) begin
            lock_in = lock_dec;
            if (lock_dec == '0) begin
               mode_in = M_IDLE;
               ev      = EV_LOCK_OVER;
            end
         end
      end else if (mode_ff == M_LOCKED) begin
         ev = EV_IGNORED;
      end else if (mode_ff == M_IDLE) begin
         // The opening key only selects the kind of entry.
         mode_in  = q_cmd.is_star ? M_OLD : M_ENTER;
         idx_in   = '0;
         entry_in = '0;
         ev       = EV_TAKEN;
      end else if (q_cmd.is_marker) begin
         ev = EV_IGNORED;
      end else if (idx_ff != IDX_W'(CODE_LENGTH - 1)) begin
         entry_in = entry_full;
         idx_in   = idx_ff + 1'b1;
         ev       = EV_TAKEN;
      end else begin
         entry_in = entry_full;
         idx_in   = '0;
         unique case (mode_ff)
            M_ENTER: begin
               mode_in = M_IDLE;
               if (entry_full == stored_ff) begin
                  fail_in = '0;
                  ev      = EV_UNLOCK;
               end else begin
                  fail_in = fail_inc;
                  ev      = EV_WRONG;
                  if (fail_inc > cfg.threshold && lock_time != '0) begin
                     lock_in = lock_time;
                     mode_in = M_LOCKED;
                  end
               end
            end
            M_OLD: begin
               if (entry_full == stored_ff || entry_full == master_cmp) begin
                  mode_in  = M_NEW;
                  entry_in = '0;
                  ev       = EV_TAKEN;
               end else begin
                  mode_in = M_IDLE;
                  ev      = EV_WRONG;
               end
            end
            M_NEW: begin
               newc_in  = entry_full;
               mode_in  = M_CONFIRM;
               entry_in = '0;
               ev       = EV_TAKEN;
            end
            default: begin
               mode_in = M_IDLE;
               if (entry_full == newc_ff) begin
                  stored_in = newc_ff;
                  ev        = EV_CHANGED;
               end else begin
                  ev = EV_MISMATCH;
               end
            end
         endcase
      end
      rsp_data_in = {2'b00, lock_in, fail_in, KEYS_W'(idx_in), mode_in, ev};
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_IDLE;
         idx_ff       <= '0;
         fail_ff      <= '0;
         lock_ff      <= '0;
         stored_ff    <= STORED_RESET;
         entry_ff     <= '0;
         newc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            mode_ff   <= mode_in;
            idx_ff    <= idx_in;
            fail_ff   <= fail_in;
            lock_ff   <= lock_in;
            stored_ff <= stored_in;
            entry_ff  <= entry_in;
            newc_ff   <= newc_in;
         end
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign stat.mode    = mode_ff;
   assign stat.keys    = KEYS_W'(idx_ff);
   assign stat.lockout = lock_ff;

endmodule

`default_nettype wire

@@ hdl/keypad_code_lock_controller.sv @@
// Top level of the keypad code lock controller: configuration registers,
// front end, command queue and execution stage. Depends on lcc_pkg,
// lcc_front, lcc_queue and lcc_back.
`default_nettype none

//  Channel   Direction  Handshake               Contents
//  req_      in         tvalid/tready           tuser: req_type, tdata: key_code
//  rsp_      out        tvalid/tready           tdata: event, mode, keys, failures,
//                                                      lockout seconds left
//  csr_      in         csr_we (no wait)        csr_addr selects, csr_wdata value
//
// A new word is accepted every cycle as long as results are taken. An accepted
// word waits in the two-entry command queue until the execution stage pops it;
// the pop registers its result in the output register, which offers it from
// then on. The lock state machine, with its parallel ten-nibble compares, sets
// that rate.
// Reset is synchronous and active high; it restores the configuration and the
// stored code to their defaults and empties the queue.
// A stalled result holds in the output register while the queue keeps taking
// words; req_tready drops only when the queue is full.

module keypad_code_lock_controller (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [lcc_pkg::REQ_DATA_W-1:0]  req_tdata,   // [3:0] key_code
   input  wire logic                            req_tuser,   // [0] req_type
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [2:0] event_res, [5:3] mode, [9:6] keys_entered, [17:10] failures,
   // [29:18] lockout_left
   output logic [lcc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [lcc_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  wire logic [lcc_pkg::MASTER_W-1:0]    csr_wdata
);
   import lcc_pkg::*;

   // Configuration registers; writes to an unused index are dropped.
   logic [MASTER_W-1:0] master_ff;
   logic [THR_W-1:0]    thr_ff;
   logic [UNIT_W-1:0]   unit_ff;
   cfg_type             cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= MASTER_RESET;
         thr_ff    <= THR_RESET;
         unit_ff   <= UNIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MASTER:    master_ff <= csr_wdata;
            CSR_THRESHOLD: thr_ff    <= csr_wdata[THR_W-1:0];
            CSR_UNIT:      unit_ff   <= csr_wdata[UNIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.master    = master_ff;
   assign cfg.threshold = thr_ff;
   assign cfg.unit      = unit_ff;

   // The front end classifies each word and hands it to the queue.
   logic     q_full;
   logic     q_push;
   cmd_type  push_cmd;
   logic     q_pop;
   logic     q_valid;
   cmd_type  pop_cmd;
   stat_type stat;

   lcc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   lcc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (push_cmd),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (pop_cmd),
      .valid (q_valid)
   );

   // The execution stage pops a command whenever its result register is free
   // or is being emptied in the same cycle.
   lcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .stat       (stat)
   );

   // A lockout always has time left; it ends on the tick that reaches zero.
   a_locked_has_time : assert property (@(posedge clock) disable iff (reset)
      stat.mode == M_LOCKED |-> stat.lockout != '0)
      else $error("locked out with no lockout time left");

   // Idle never leaves a partial entry behind.
   a_idle_no_keys : assert property (@(posedge clock) disable iff (reset)
      stat.mode == M_IDLE |-> stat.keys == '0)
      else $error("idle with keys still counted");

   // An unlock result always reports a cleared failure count.
   a_unlock_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == EV_UNLOCK |-> rsp_tdata[17:10] == '0)
      else $error("unlock reported with failures outstanding");

   // The queue pops only while it holds a command.
   a_pop_needs_cmd : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command popped from an empty queue");

endmodule

`default_nettype wire
